// File: rtl/vslt_pkg.sv
package vslt_pkg;

    localparam int ROW_BYTES_DEF   = 64;
    localparam int STORE_ROWS_DEF  = 512;
    localparam int LINE_REPEAT_DEF = 3;

    localparam int H_VISIBLE    = 1024;
    localparam int H_SYNC_START = 1048;
    localparam int H_SYNC_END   = 1184;
    localparam int H_TOTAL      = 1344;
    localparam int V_VISIBLE    = 768;
    localparam int V_SYNC_START = 771;
    localparam int V_SYNC_END   = 777;
    localparam int V_TOTAL      = 806;

    localparam int COL_W      = 11;
    localparam int LINE_W     = 10;
    localparam int ADDR_IN_W  = 15;
    localparam int DATA_W     = 8;
    localparam int PIX_W      = 3;
    localparam int SUB_W      = 4;
    localparam int BYTE_IDX_W = 6;
    localparam int ROW_OFS_W  = 9;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [ROW_OFS_W-1:0] ROW_OFFSET_RESET = 9'd41;
    localparam logic [PIX_W-1:0]     MONO_ON          = 3'd7;
    localparam logic [PIX_W-1:0]     PIX_BLANK        = 3'd0;

    localparam logic REG_COLOR_MODE = 1'b0;
    localparam logic REG_ROW_OFFSET = 1'b1;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef struct packed {
        logic                 color_mode;
        logic [ROW_OFS_W-1:0] row_offset;
    } cfg_t;

    typedef struct packed {
        logic                  hsync;
        logic                  vsync;
        logic                  data_enable;
        logic [SUB_W-1:0]      sub;
        logic [BYTE_IDX_W-1:0] byte_idx;
        logic [LINE_W-1:0]     line_quot;
    } timing_t;

    // number of conditional subtractions of modulus<<k that bring max_val below modulus
    function automatic int reduce_steps(int max_val, int modulus);
        int n;
        n = 0;
        for (int k = 0; k < 16; k++)
        begin
            if ((modulus << k) <= max_val)
            begin
                n = k + 1;
            end
        end
        return n;
    endfunction

    function automatic logic [PIX_W-1:0] colour_code(logic [1:0] pair);
        logic [PIX_W-1:0] code;
        unique case (pair)
            2'd0: code = 3'd0;
            2'd1: code = 3'd4;
            2'd2: code = 3'd2;
            2'd3: code = 3'd1;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/vslt_regs.sv
module vslt_regs
    import vslt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic                 color_mode_reg;
    logic [ROW_OFS_W-1:0] row_offset_reg;
    logic                 reg_idx;
    logic                 wr_req;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_req  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= 1'b0;
            row_offset_reg <= ROW_OFFSET_RESET;
        end
        else if (wr_req)
        begin
            unique case (reg_idx)
                REG_COLOR_MODE: color_mode_reg <= pwdata[0];
                REG_ROW_OFFSET: row_offset_reg <= pwdata[ROW_OFS_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_COLOR_MODE: prdata = APB_DATA_W'(color_mode_reg);
            REG_ROW_OFFSET: prdata = APB_DATA_W'(row_offset_reg);
        endcase
    end

    assign cfg.color_mode = color_mode_reg;
    assign cfg.row_offset = row_offset_reg;

endmodule

// File: rtl/vslt_timing.sv
module vslt_timing
    import vslt_pkg::*;
#(
    parameter int LINE_REPEAT = LINE_REPEAT_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    output timing_t timing
);

    localparam int REP_W = (LINE_REPEAT > 1) ? $clog2(LINE_REPEAT) : 1;
    localparam logic [REP_W-1:0] REP_LAST = REP_W'(LINE_REPEAT - 1);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [REP_W-1:0]  rep_reg, rep_next;
    logic [LINE_W-1:0] quot_reg, quot_next;

    always_comb
    begin
        col_next  = col_reg;
        line_next = line_reg;
        rep_next  = rep_reg;
        quot_next = quot_reg;
        if (advance)
        begin
            if (col_reg == COL_W'(H_TOTAL - 1))
            begin
                col_next = '0;
                if (line_reg == LINE_W'(V_TOTAL - 1))
                begin
                    line_next = '0;
                    rep_next  = '0;
                    quot_next = '0;
                end
                else
                begin
                    line_next = line_reg + 1'b1;
                    if (rep_reg == REP_LAST)
                    begin
                        rep_next  = '0;
                        quot_next = quot_reg + 1'b1;
                    end
                    else
                    begin
                        rep_next = rep_reg + 1'b1;
                    end
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= '0;
            rep_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
            rep_reg  <= rep_next;
            quot_reg <= quot_next;
        end
    end

    assign timing.hsync = !((col_reg >= COL_W'(H_SYNC_START)) && (col_reg < COL_W'(H_SYNC_END)));
    assign timing.vsync = !((line_reg >= LINE_W'(V_SYNC_START))
                            && (line_reg < LINE_W'(V_SYNC_END)));
    assign timing.data_enable = (col_reg < COL_W'(H_VISIBLE)) && (line_reg < LINE_W'(V_VISIBLE));
    assign timing.sub       = col_reg[SUB_W-1:0];
    assign timing.byte_idx  = col_reg[SUB_W +: BYTE_IDX_W];
    assign timing.line_quot = quot_reg;

`ifndef ASSERT_OFF
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < COL_W'(H_TOTAL))
        else $error("pixel column out of range");
    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg < LINE_W'(V_TOTAL))
        else $error("line number out of range");
    a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
        rep_reg <= REP_LAST)
        else $error("line repeat counter out of range");
`endif

endmodule

// File: rtl/vslt_store.sv
module vslt_store
    import vslt_pkg::*;
#(
    parameter int DEPTH  = ROW_BYTES_DEF * STORE_ROWS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/video_scanout_line_tripler.sv
// 1024x768 scan-out with a byte frame store. One request is taken per clock, write or
// tick alike, unless pix_ready stalls a full pipeline; a tick passes position and row
// lookup, frame-store read and pixel decode. Every request passes stage A once, where
// writes use the write port and in-range visible ticks the read port. Each store row
// (starting at row_offset) is shown on LINE_REPEAT lines; bytes are inverted and shifted
// out LSB first, two pixels per bit in mono or four per bit pair in colour mode. The
// store is not cleared at reset: fill it before scan-out reaches the visible area.
module video_scanout_line_tripler
    import vslt_pkg::*;
#(
    parameter int ROW_BYTES   = ROW_BYTES_DEF,
    parameter int STORE_ROWS  = STORE_ROWS_DEF,
    parameter int LINE_REPEAT = LINE_REPEAT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic                  kind,
    input  logic [ADDR_IN_W-1:0]  write_address,
    input  logic [DATA_W-1:0]     write_data,
    output logic                  pix_valid,
    input  logic                  pix_ready,
    output logic                  hsync,
    output logic                  vsync,
    output logic                  data_enable,
    output logic [PIX_W-1:0]      pixel
);

    localparam int STORE_SIZE = ROW_BYTES * STORE_ROWS;
    localparam int SA_W       = $clog2(STORE_SIZE);
    localparam int ROW_W      = $clog2(STORE_ROWS);
    localparam int SUM_W      = ROW_OFS_W + 2;
    localparam int WA_STEPS   = reduce_steps((1 << ADDR_IN_W) - 1, STORE_SIZE);
    localparam int ROW_STEPS  = reduce_steps((1 << SUM_W) - 1, STORE_ROWS);

    cfg_t    cfg;
    timing_t timing;

    logic accept;
    logic tick_accept;
    logic a_en, b_en, out_adv;

    logic [ADDR_IN_W-1:0] wa_rem;
    logic [SUM_W-1:0]     row_rem;
    logic                 oob;

    logic                  a_v_reg;
    logic                  a_tick_reg;
    logic [SA_W-1:0]       a_waddr_reg;
    logic [DATA_W-1:0]     a_wdata_reg;
    logic [ROW_W-1:0]      a_row_reg;
    logic [BYTE_IDX_W-1:0] a_byte_reg;
    logic                  a_hs_reg, a_vs_reg, a_de_reg, a_oob_reg;
    logic [SUB_W-1:0]      a_sub_reg;

    logic                  b_v_reg;
    logic                  b_hs_reg, b_vs_reg, b_de_reg, b_oob_reg;
    logic [SUB_W-1:0]      b_sub_reg;

    logic                  out_v_reg;
    logic                  hsync_reg, vsync_reg, de_reg;
    logic [PIX_W-1:0]      pixel_reg, pixel_next;

    logic                  st_wr_en, st_rd_en;
    logic [SA_W-1:0]       st_rd_addr;
    logic [DATA_W-1:0]     st_rd_data;
    logic [DATA_W-1:0]     shown;

    vslt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vslt_timing #(
        .LINE_REPEAT (LINE_REPEAT)
    ) u_timing (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (tick_accept),
        .timing  (timing)
    );

    assign out_adv     = !out_v_reg || pix_ready;
    assign b_en        = out_adv || !b_v_reg;
    assign a_en        = b_en || !a_v_reg;
    assign req_ready   = a_en;
    assign accept      = req_valid && a_en;
    assign tick_accept = accept && (kind == KIND_TICK);

    always_comb
    begin
        wa_rem = write_address;
        for (int k = WA_STEPS - 1; k >= 0; k--)
        begin
            if (32'(wa_rem) >= (32'(STORE_SIZE) << k))
            begin
                wa_rem = wa_rem - ADDR_IN_W'(32'(STORE_SIZE) << k);
            end
        end
    end

    always_comb
    begin
        row_rem = SUM_W'(cfg.row_offset) + SUM_W'(timing.line_quot);
        for (int k = ROW_STEPS - 1; k >= 0; k--)
        begin
            if (32'(row_rem) >= (32'(STORE_ROWS) << k))
            begin
                row_rem = row_rem - SUM_W'(32'(STORE_ROWS) << k);
            end
        end
    end

    assign oob = 32'(timing.byte_idx) >= 32'(ROW_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_v_reg <= accept;
            end
            if (b_en)
            begin
                b_v_reg <= a_v_reg && a_tick_reg;
            end
            if (out_adv)
            begin
                out_v_reg <= b_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_tick_reg  <= (kind == KIND_TICK);
            a_waddr_reg <= SA_W'(wa_rem);
            a_wdata_reg <= write_data;
            a_row_reg   <= ROW_W'(row_rem);
            a_byte_reg  <= timing.byte_idx;
            a_hs_reg    <= timing.hsync;
            a_vs_reg    <= timing.vsync;
            a_de_reg    <= timing.data_enable;
            a_oob_reg   <= oob;
            a_sub_reg   <= timing.sub;
        end
        if (b_en)
        begin
            b_hs_reg  <= a_hs_reg;
            b_vs_reg  <= a_vs_reg;
            b_de_reg  <= a_de_reg;
            b_oob_reg <= a_oob_reg;
            b_sub_reg <= a_sub_reg;
        end
        if (out_adv)
        begin
            hsync_reg <= b_hs_reg;
            vsync_reg <= b_vs_reg;
            de_reg    <= b_de_reg;
            pixel_reg <= pixel_next;
        end
    end

    // writes and display reads are issued to the store from stage A, in request order
    assign st_wr_en   = b_en && a_v_reg && !a_tick_reg;
    assign st_rd_en   = b_en && a_v_reg && a_tick_reg && a_de_reg && !a_oob_reg;
    assign st_rd_addr = SA_W'(32'(a_row_reg) * 32'(ROW_BYTES)) + SA_W'(a_byte_reg);

    vslt_store #(
        .DEPTH  (STORE_SIZE),
        .ADDR_W (SA_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (a_waddr_reg),
        .wr_data (a_wdata_reg),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    assign shown = ~st_rd_data;

    always_comb
    begin
        priority if (!b_de_reg || b_oob_reg)
        begin
            pixel_next = PIX_BLANK;
        end
        else if (cfg.color_mode)
        begin
            pixel_next = colour_code(shown[{b_sub_reg[3:2], 1'b0} +: 2]);
        end
        else
        begin
            pixel_next = shown[b_sub_reg[3:1]] ? MONO_ON : PIX_BLANK;
        end
    end

    assign pix_valid   = out_v_reg;
    assign hsync       = hsync_reg;
    assign vsync       = vsync_reg;
    assign data_enable = de_reg;
    assign pixel       = pixel_reg;

`ifndef ASSERT_OFF
    a_blank_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !data_enable |-> pixel == PIX_BLANK)
        else $error("pixel lit outside the visible area");
    a_visible_no_sync: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && data_enable |-> hsync && vsync)
        else $error("sync pulse during visible pixel");
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> a_v_reg && b_v_reg && out_v_reg)
        else $error("request stalled with an empty stage");
`endif

endmodule
